/* sv/qea_pkg.sv */
// qea_pkg: shared widths, register codes, stage-boundary structs and the arctangent table
// function for the quaternion error angle-axis unit.
// No dependencies; every other file of the unit imports it.
package qea_pkg;

	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// normalized magnitudes, root and angle widths
	localparam int NORM_BITS = 30;
	localparam int ROOT_BITS = 31;
	localparam int ANG_FRAC  = 30;
	localparam int CX_W      = 34;
	localparam int CZ_W      = 33;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_REF_W = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_X = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 4'd3;

	localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314857;

	// relative rotation after the common normalizing shift
	typedef struct packed {
		logic [NORM_BITS-1:0]      xw;
		logic [2:0][NORM_BITS-1:0] vm;
		logic [2:0]                vneg;
		logic                      wneg;
	} norm_t;

	// plus the vector length
	typedef struct packed {
		norm_t                nm;
		logic [ROOT_BITS-1:0] s;
	} root_t;

	// plus the half angle from the cordic
	typedef struct packed {
		norm_t                   nm;
		logic [ROOT_BITS-1:0]    s;
		logic signed [CZ_W-1:0]  z;
	} ang_t;

	// atan(2^-i) in Q.30 radians from the odd power series, evaluated at elaboration
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [63:0] acc_pos;
		logic [63:0] acc_neg;
		logic [63:0] num;
		logic [63:0] term;
		logic [63:0] rem;
		logic [63:0] sum;
		int unsigned sh;
		int unsigned d;
		acc_pos = '0;
		acc_neg = '0;
		if (i == 0) return QUARTER_PI_Q30;
		for (int unsigned k = 0; k < 64; k++) begin
			sh = i * (2 * k + 1);
			if (sh < 60) begin
				num  = 64'd1 << (60 - sh);
				d    = 2 * k + 1;
				term = '0;
				rem  = '0;
				// long division of the series term by its odd index
				for (int b = 63; b >= 0; b--) begin
					rem = {rem[62:0], num[b]};
					if (rem >= 64'(d)) begin
						rem     = rem - 64'(d);
						term[b] = 1'b1;
					end
				end
				if (k[0]) acc_neg = acc_neg + term;
				else acc_pos = acc_pos + term;
			end
		end
		sum = acc_pos - acc_neg + (64'd1 << 29);
		return sum[61:30];
	endfunction

endpackage

/* sv/qea_if.sv */
// qea_if: valid/ready channel interfaces for sample items, error items and register writes.
// Depends on qea_pkg for the default sample width and the register index width.
interface qea_in_if #(parameter int SAMPLE_BITS = qea_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_w;
	logic signed [SAMPLE_BITS-1:0] in_x;
	logic signed [SAMPLE_BITS-1:0] in_y;
	logic signed [SAMPLE_BITS-1:0] in_z;
	modport source (output valid, in_w, in_x, in_y, in_z, input ready);
	modport sink (input valid, in_w, in_x, in_y, in_z, output ready);
endinterface

interface qea_out_if #(parameter int SAMPLE_BITS = qea_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] err_x;
	logic signed [SAMPLE_BITS-1:0] err_y;
	logic signed [SAMPLE_BITS-1:0] err_z;
	logic                          clipped;
	modport source (output valid, err_x, err_y, err_z, clipped, input ready);
	modport sink (input valid, err_x, err_y, err_z, clipped, output ready);
endinterface

interface qea_cfg_if #(parameter int SAMPLE_BITS = qea_pkg::SAMPLE_BITS_DEF);
	import qea_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [SAMPLE_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/qea_front.sv */
// qea_front: quaternion product r * conj(q), then the common normalizing shift.
// Four register stages; depends on qea_pkg.
module qea_front #(
	parameter int SAMPLE_BITS = qea_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [3:0][SAMPLE_BITS-1:0] ref_q,
	input  logic [3:0][SAMPLE_BITS-1:0] in_q,
	output logic                        out_valid,
	output qea_pkg::norm_t              nm
);
	import qea_pkg::*;

	localparam int PRE = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
	localparam int OW  = SAMPLE_BITS - PRE;
	localparam int PW  = 2 * OW;
	// four products of full-scale negative operands sum to +2^(2*OW)
	localparam int PS  = 2 * OW + 2;
	localparam int KW  = 6;

	// operand pairs of the sixteen partial products, four per output component
	localparam int AI [16] = '{0, 1, 2, 3, 1, 0, 2, 3, 2, 0, 3, 1, 3, 0, 1, 2};
	localparam int BI [16] = '{0, 1, 2, 3, 0, 1, 3, 2, 0, 2, 1, 3, 0, 3, 2, 1};

	// magnitude shift toward zero for wide samples
	function automatic logic signed [OW-1:0] pre_shift(input logic [SAMPLE_BITS-1:0] raw);
		logic signed [SAMPLE_BITS:0] v;
		logic [SAMPLE_BITS:0]        m;
		v = $signed({raw[SAMPLE_BITS-1], raw});
		m = v[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-v) : (SAMPLE_BITS+1)'(v);
		m = m >> PRE;
		return v[SAMPLE_BITS] ? OW'(-m) : OW'(m);
	endfunction

	logic signed [OW-1:0] a [4];
	logic signed [OW-1:0] b [4];
	logic signed [PW-1:0] prod_s1 [16];
	logic signed [PS-1:0] sum_s2 [4];
	logic [PS-1:0]        mag_s3 [4];
	logic [3:0]           neg_s3;
	logic [KW-1:0]        k_s3;
	logic [PS-1:0]        mag_c [4];
	logic [PS-1:0]        orv;
	logic [KW-1:0]        k_c;
	logic                 v_s1, v_s2, v_s3;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			a[j] = pre_shift(ref_q[j]);
			b[j] = pre_shift(in_q[j]);
		end
	end

	// magnitudes and the shift that brings the largest below 2^30
	always_comb begin
		orv = '0;
		k_c = '0;
		for (int j = 0; j < 4; j++) begin
			mag_c[j] = sum_s2[j][PS-1] ? PS'(-sum_s2[j]) : PS'(sum_s2[j]);
			orv      = orv | mag_c[j];
		end
		for (int j = NORM_BITS; j < PS; j++) begin
			if (orv[j]) k_c = KW'(j - NORM_BITS + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 16; p++) prod_s1[p] <= a[AI[p]] * b[BI[p]];
			sum_s2[0] <= PS'(prod_s1[0]) + PS'(prod_s1[1]) + PS'(prod_s1[2]) + PS'(prod_s1[3]);
			for (int r = 1; r < 4; r++) begin
				sum_s2[r] <= PS'(prod_s1[4*r]) - PS'(prod_s1[4*r+1])
				           - PS'(prod_s1[4*r+2]) + PS'(prod_s1[4*r+3]);
			end
			for (int j = 0; j < 4; j++) begin
				mag_s3[j] <= mag_c[j];
				neg_s3[j] <= sum_s2[j][PS-1];
			end
			k_s3 <= k_c;
			nm.xw   <= NORM_BITS'(mag_s3[0] >> k_s3);
			nm.wneg <= neg_s3[0];
			for (int j = 0; j < 3; j++) begin
				nm.vm[j]   <= NORM_BITS'(mag_s3[j+1] >> k_s3);
				nm.vneg[j] <= neg_s3[j+1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

endmodule

/* sv/qea_isqrt.sv */
// qea_isqrt: squared length of the vector part and its integer square root, one root bit a stage.
// ROOT_BITS + 2 register stages; depends on qea_pkg.
module qea_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  qea_pkg::norm_t nm_in,
	output logic           out_valid,
	output qea_pkg::root_t res
);
	import qea_pkg::*;

	localparam int STEPS = ROOT_BITS;
	localparam int RW    = 2 * ROOT_BITS + 1;

	logic [2*NORM_BITS-1:0] sq_s1 [3];
	norm_t                  nm_s1;
	logic                   v_s1;
	logic [RW-1:0]          n_s  [STEPS+1];
	logic [RW-1:0]          rt_s [STEPS+1];
	norm_t                  nm_s [STEPS+1];
	logic [STEPS:0]         v_s;

	// squares, then their sum enters the root chain
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) sq_s1[j] <= nm_in.vm[j] * nm_in.vm[j];
			nm_s1   <= nm_in;
			n_s[0]  <= RW'(sq_s1[0]) + RW'(sq_s1[1]) + RW'(sq_s1[2]);
			rt_s[0] <= '0;
			nm_s[0] <= nm_s1;
		end
	end

	// one digit step per stage
	for (genvar t = 0; t < STEPS; t++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - t));
		logic [RW-1:0] trial;
		assign trial = rt_s[t] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_s[t] >= trial) begin
					n_s[t+1]  <= n_s[t] - trial;
					rt_s[t+1] <= (rt_s[t] >> 1) + BIT;
				end else begin
					n_s[t+1]  <= n_s[t];
					rt_s[t+1] <= rt_s[t] >> 1;
				end
				nm_s[t+1] <= nm_s[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s  <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s  <= {v_s[STEPS-1:0], v_s1};
		end
	end

	assign out_valid = v_s[STEPS];
	assign res.nm    = nm_s[STEPS];
	assign res.s     = rt_s[STEPS][ROOT_BITS-1:0];

endmodule

/* sv/qea_cordic.sv */
// qea_cordic: vectoring cordic giving atan2(length, |w|) in Q.30 radians, one rotation a stage.
// CORDIC_STEPS + 1 register stages; depends on qea_pkg.
module qea_cordic #(
	parameter int CORDIC_STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  qea_pkg::root_t rt_in,
	output logic           out_valid,
	output qea_pkg::ang_t  res
);
	import qea_pkg::*;

	logic signed [CX_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CZ_W-1:0] z_s [CORDIC_STEPS+1];
	root_t                  rt_s [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0]  v_s;

	// load the vector (|w|, length)
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= $signed(CX_W'(rt_in.nm.xw));
			y_s[0]  <= $signed(CX_W'(rt_in.s));
			z_s[0]  <= '0;
			rt_s[0] <= rt_in;
		end
	end

	// rotate toward the x axis, accumulate the angle
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam logic [31:0] AT = atan_q30(i);
		logic signed [CX_W-1:0] dx, dy;
		logic signed [CZ_W-1:0] at_s;
		assign dx   = y_s[i] >>> i;
		assign dy   = x_s[i] >>> i;
		assign at_s = $signed({1'b0, AT});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][CX_W-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at_s;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at_s;
				end
				rt_s[i+1] <= rt_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[CORDIC_STEPS-1:0], in_valid};
	end

	assign out_valid = v_s[CORDIC_STEPS];
	assign res.nm    = rt_s[CORDIC_STEPS].nm;
	assign res.s     = rt_s[CORDIC_STEPS].s;
	assign res.z     = z_s[CORDIC_STEPS];

endmodule

/* sv/qea_div.sv */
// qea_div: scales each vector component by angle / length with a restoring divider per
// component (one quotient bit a stage), then rounds, signs and saturates. Depends on qea_pkg.
module qea_div #(
	parameter int SAMPLE_BITS = qea_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  qea_pkg::ang_t               ang_in,
	output logic                        out_valid,
	output logic [2:0][SAMPLE_BITS-1:0] err,
	output logic                        clip
);
	import qea_pkg::*;

	localparam int QB    = SAMPLE_BITS;
	localparam int DW    = 64;
	localparam int CW    = DW + QB;
	localparam int HS    = ANG_FRAC - (SAMPLE_BITS - 3);
	localparam int DS    = HS + 1;
	localparam int ZM    = CZ_W - 1;
	localparam int NUM_W = NORM_BITS + ZM;
	localparam logic [QB-1:0] LIM_POS = (QB'(1) << (SAMPLE_BITS - 1)) - QB'(1);
	localparam logic [QB-1:0] LIM_NEG = QB'(1) << (SAMPLE_BITS - 1);

	logic [ZM-1:0]        za_s1;
	logic                 angneg_s1;
	norm_t                nm_s1;
	logic [ROOT_BITS-1:0] len_s1;
	logic [NUM_W-1:0]     num_s2 [3];
	logic [2:0]           sgn_s2;
	logic [ROOT_BITS-1:0] len_s2;
	logic [DW-1:0]        rem_s [QB+1][3];
	logic [QB-1:0]        q_s   [QB+1][3];
	logic [DW-1:0]        dv_s  [QB+1];
	logic [2:0]           sgn_s [QB+1];
	logic                 zero_s [QB+1];
	logic                 v_s1, v_s2;
	logic [QB:0]          v_s;
	logic [2:0][SAMPLE_BITS-1:0] err_c;
	logic [2:0]                  clip_c;

	// angle magnitude and its sign after the scalar flip
	always_ff @(posedge clk) begin
		if (en) begin
			za_s1     <= ang_in.z[CZ_W-1] ? ZM'(-ang_in.z) : ZM'(ang_in.z);
			angneg_s1 <= ang_in.nm.wneg ? (!ang_in.z[CZ_W-1] && ang_in.z != '0)
			                            : ang_in.z[CZ_W-1];
			nm_s1     <= ang_in.nm;
			len_s1    <= ang_in.s;
		end
	end

	// component times half angle
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				num_s2[j] <= nm_s1.vm[j] * za_s1;
				sgn_s2[j] <= nm_s1.vneg[j] ^ angneg_s1;
			end
			len_s2 <= len_s1;
		end
	end

	// rounding offset added to the dividend, divisor scaled to the output fraction
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				rem_s[0][j] <= {num_s2[j], 2'b00} + (DW'(len_s2) << HS);
				q_s[0][j]   <= '0;
			end
			dv_s[0]   <= DW'(len_s2) << DS;
			sgn_s[0]  <= sgn_s2;
			zero_s[0] <= (len_s2 == '0);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar t = 0; t < QB; t++) begin : g_div
		localparam int BP = QB - 1 - t;
		logic [CW-1:0] cmp;
		assign cmp = CW'(dv_s[t]) << BP;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (CW'(rem_s[t][j]) >= cmp) begin
						rem_s[t+1][j] <= rem_s[t][j] - cmp[DW-1:0];
						q_s[t+1][j]   <= q_s[t][j] | (QB'(1) << BP);
					end else begin
						rem_s[t+1][j] <= rem_s[t][j];
						q_s[t+1][j]   <= q_s[t][j];
					end
				end
				dv_s[t+1]   <= dv_s[t];
				sgn_s[t+1]  <= sgn_s[t];
				zero_s[t+1] <= zero_s[t];
			end
		end
	end

	// sign and saturation
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			clip_c[j] = 1'b0;
			if (zero_s[QB]) begin
				err_c[j] = '0;
			end else if (sgn_s[QB][j] && q_s[QB][j] != '0) begin
				if (q_s[QB][j] > LIM_NEG) begin
					err_c[j]  = SAMPLE_BITS'(LIM_NEG);
					clip_c[j] = 1'b1;
				end else begin
					err_c[j] = SAMPLE_BITS'(-q_s[QB][j]);
				end
			end else if (q_s[QB][j] > LIM_POS) begin
				err_c[j]  = SAMPLE_BITS'(LIM_POS);
				clip_c[j] = 1'b1;
			end else begin
				err_c[j] = SAMPLE_BITS'(q_s[QB][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err  <= err_c;
			clip <= |clip_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s       <= {v_s[QB-1:0], v_s2};
			out_valid <= v_s[QB];
		end
	end

endmodule

/* sv/quaternion_error_angle_axis_unit.sv */
// quaternion_error_angle_axis_unit: top level; reference registers, the pipeline and the
// output register with skid stage. Depends on qea_pkg, qea_if and the qea_* stage modules.
//
//   channel  modport  handshake     payload
//   samp     sink     valid/ready   in_w, in_x, in_y, in_z  (Q1.14)
//   err      source   valid/ready   err_x, err_y, err_z (Q2.13), clipped
//   cfg      sink     valid/ready   index, data  (ready always high)
//
// One item per cycle while samp.ready is high. Each item passes through the front, the root chain
// (one bit per stage), the cordic and the divider (one bit per stage).
// Reset loads the reference with the identity quaternion and empties the pipeline.
// A stalled result sits in the output register; one more item lands in the skid stage,
// then samp.ready drops and the whole pipeline holds until the skid stage drains.
module quaternion_error_angle_axis_unit #(
	parameter int SAMPLE_BITS  = qea_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	qea_in_if.sink       samp,
	qea_out_if.source    err,
	qea_cfg_if.sink      cfg
);
	import qea_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] REF_W_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);

	logic [SAMPLE_BITS-1:0] ref_w_q, ref_x_q, ref_y_q, ref_z_q;
	logic [3:0][SAMPLE_BITS-1:0] ref_q, in_q;
	logic                        en;
	logic                        fr_v, rt_v, cd_v, pipe_v;
	norm_t                       fr_nm;
	root_t                       rt_res;
	ang_t                        cd_res;
	logic [2:0][SAMPLE_BITS-1:0] pipe_err;
	logic                        pipe_clip;
	logic [2:0][SAMPLE_BITS-1:0] out_err_q, skid_err_q;
	logic                        out_clip_q, skid_clip_q;
	logic                        out_v_q, skid_v_q;

	// reference registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_w_q <= REF_W_RST;
			ref_x_q <= '0;
			ref_y_q <= '0;
			ref_z_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_REF_W: ref_w_q <= cfg.data;
				REG_REF_X: ref_x_q <= cfg.data;
				REG_REF_Y: ref_y_q <= cfg.data;
				REG_REF_Z: ref_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign ref_q = {ref_z_q, ref_y_q, ref_x_q, ref_w_q};
	assign in_q  = {samp.in_z, samp.in_y, samp.in_x, samp.in_w};

	// the pipeline moves whenever the skid stage is free
	assign en         = !skid_v_q;
	assign samp.ready = en;

	qea_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (samp.valid),
		.ref_q     (ref_q),
		.in_q      (in_q),
		.out_valid (fr_v),
		.nm        (fr_nm)
	);

	qea_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.nm_in     (fr_nm),
		.out_valid (rt_v),
		.res       (rt_res)
	);

	qea_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_v),
		.rt_in     (rt_res),
		.out_valid (cd_v),
		.res       (cd_res)
	);

	qea_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cd_v),
		.ang_in    (cd_res),
		.out_valid (pipe_v),
		.err       (pipe_err),
		.clip      (pipe_clip)
	);

	// output register and skid stage, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || err.ready) begin
			out_v_q  <= skid_v_q || pipe_v;
			skid_v_q <= 1'b0;
		end else if (pipe_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	// output register and skid stage, data
	always_ff @(posedge clk) begin
		if (!out_v_q || err.ready) begin
			if (skid_v_q) begin
				out_err_q  <= skid_err_q;
				out_clip_q <= skid_clip_q;
			end else begin
				out_err_q  <= pipe_err;
				out_clip_q <= pipe_clip;
			end
		end else if (pipe_v && !skid_v_q) begin
			skid_err_q  <= pipe_err;
			skid_clip_q <= pipe_clip;
		end
	end

	assign err.valid   = out_v_q;
	assign err.err_x   = out_err_q[0];
	assign err.err_y   = out_err_q[1];
	assign err.err_z   = out_err_q[2];
	assign err.clipped = out_clip_q;

	// skid stage only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds an item with the output register empty");

	// a finished item meeting a stalled output is caught by the skid stage
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !err.ready && pipe_v && !skid_v_q) |=> skid_v_q)
		else $error("finished item dropped at a stalled output");

	// draining the skid stage refills the output register
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && err.ready) |=> (out_v_q && !skid_v_q))
		else $error("skid item lost while draining");

endmodule

/* tb/quaternion_error_angle_axis_unit_tb.sv */
// quaternion_error_angle_axis_unit_tb: stimulus, angle-axis predictor and checker for the unit.
// Depends on qea_pkg, qea_if and the unit's RTL; drives sample and register channels,
// compares every error item against a bit-exact prediction.
`timescale 1ns / 100ps

module quaternion_error_angle_axis_unit_tb;
	import qea_pkg::*;

	localparam int SB = 16;
	localparam int STEPS = 16;
	localparam int LATENCY = 43 + STEPS + SB;

	typedef struct packed {
		logic signed [SB-1:0] w;
		logic signed [SB-1:0] x;
		logic signed [SB-1:0] y;
		logic signed [SB-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [SB-1:0] ex;
		logic signed [SB-1:0] ey;
		logic signed [SB-1:0] ez;
		logic                 clip;
	} err_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qea_in_if #(.SAMPLE_BITS(SB)) samp();
	qea_out_if #(.SAMPLE_BITS(SB)) err();
	qea_cfg_if #(.SAMPLE_BITS(SB)) cfg();

	quaternion_error_angle_axis_unit #(.SAMPLE_BITS(SB), .CORDIC_STEPS(STEPS)) i_dut (
		.clk(clk), .arst_n(arst_n), .samp(samp), .err(err), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// reference quaternion as the predictor sees it
	quat_t ref_q = '{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0};
	quat_t sample_queue[$];
	err_vec_t expected_errs[$];
	bit failed = 0;
	bit quiet = 0;
	logic [63:0] atan_lut[32];

	initial for (int i = 0; i < 32; i++) atan_lut[i] = 64'(atan_q30(i));

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [63:0] shr_keep_sign(input logic signed [63:0] v,
			input int s);
		logic [63:0] m;
		m = mag64(v) >> s;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// vectoring cordic, both operands non-negative
	function automatic logic signed [63:0] cordic_angle(input logic signed [63:0] cx,
			input logic signed [63:0] cy);
		logic signed [63:0] za;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		za = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx; cy -= dy; za += $signed(atan_lut[i]);
			end else begin
				cx -= dx; cy += dy; za -= $signed(atan_lut[i]);
			end
		end
		return za;
	endfunction

	function automatic err_vec_t predict_error(input quat_t q);
		logic signed [63:0] aw, ax, ay, az, bw, bx, by, bz, pw, ang, rr;
		logic signed [63:0] pv[3];
		logic [63:0] m, s, num, den, qq;
		logic [63:0] hi;
		int k;
		bit neg;
		err_vec_t r;
		aw = ref_q.w; ax = ref_q.x; ay = ref_q.y; az = ref_q.z;
		bw = q.w; bx = q.x; by = q.y; bz = q.z;
		hi = (64'd1 << (SB - 1)) - 1;
		r = '0;
		pw = aw * bw + ax * bx + ay * by + az * bz;
		pv[0] = bw * ax - aw * bx - ay * bz + az * by;
		pv[1] = bw * ay - aw * by - az * bx + ax * bz;
		pv[2] = bw * az - aw * bz - ax * by + ay * bx;
		m = mag64(pw);
		for (int j = 0; j < 3; j++) if (mag64(pv[j]) > m) m = mag64(pv[j]);
		k = 0;
		while ((m >> k) >= (64'd1 << NORM_BITS)) k++;
		for (int j = 0; j < 3; j++) pv[j] = shr_keep_sign(pv[j], k);
		s = int_sqrt(mag64(pv[0]) * mag64(pv[0]) + mag64(pv[1]) * mag64(pv[1])
			+ mag64(pv[2]) * mag64(pv[2]));
		if (s == 0) return r;
		ang = cordic_angle($signed(mag64(pw) >> k), $signed(s));
		if (pw < 0) ang = -ang;
		ang = ang * 2;
		for (int j = 0; j < 3; j++) begin
			num = mag64(pv[j]) * mag64(ang);
			den = s << (ANG_FRAC - (SB - 3));
			qq = (2 * num + den) / (2 * den);
			neg = ((pv[j] < 0) != (ang < 0)) && qq != 0;
			if (neg) begin
				if (qq > hi + 1) begin
					qq = hi + 1; r.clip = 1;
				end
				rr = -$signed(qq);
			end else begin
				if (qq > hi) begin
					qq = hi; r.clip = 1;
				end
				rr = $signed(qq);
			end
			case (j)
				0: r.ex = rr[SB-1:0];
				1: r.ey = rr[SB-1:0];
				default: r.ez = rr[SB-1:0];
			endcase
		end
		return r;
	endfunction

	// sample driver, fed from sample_queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp.valid <= 1'b0;
			samp.in_w <= '0; samp.in_x <= '0; samp.in_y <= '0; samp.in_z <= '0;
		end else begin
			if (samp.valid && samp.ready) begin
				expected_errs.push_back(predict_error({samp.in_w, samp.in_x,
					samp.in_y, samp.in_z}));
			end
			if (!samp.valid || samp.ready) begin
				if (sample_queue.size() > 0 && (quiet || $urandom_range(99) >= 11)) begin
					quat_t q;
					q = sample_queue.pop_front();
					samp.valid <= 1'b1;
					samp.in_w <= q.w; samp.in_x <= q.x; samp.in_y <= q.y; samp.in_z <= q.z;
				end else begin
					samp.valid <= 1'b0;
				end
			end
		end
	end

	// error item monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err.ready <= 1'b0;
		end else begin
			if (err.valid && err.ready) begin
				err_vec_t got;
				err_vec_t exp_e;
				got = '{ex: err.err_x, ey: err.err_y, ez: err.err_z, clip: err.clipped};
				if (expected_errs.size() == 0) begin
					$display("%0t: unexpected error item %h", $time, got);
					failed = 1;
				end else begin
					exp_e = expected_errs.pop_front();
					if (got.ex !== exp_e.ex)
						$display("%0t: err_x expected %0d actual %0d", $time, exp_e.ex, got.ex);
					if (got.ey !== exp_e.ey)
						$display("%0t: err_y expected %0d actual %0d", $time, exp_e.ey, got.ey);
					if (got.ez !== exp_e.ez)
						$display("%0t: err_z expected %0d actual %0d", $time, exp_e.ez, got.ez);
					if (got.clip !== exp_e.clip)
						$display("%0t: clipped expected %0b actual %0b", $time,
							exp_e.clip, got.clip);
					if (got !== exp_e) failed = 1;
				end
			end
			err.ready <= quiet || $urandom_range(99) >= 11;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SB-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_REF_W: ref_q.w = value;
			REG_REF_X: ref_q.x = value;
			REG_REF_Y: ref_q.y = value;
			REG_REF_Z: ref_q.z = value;
			default: ;
		endcase
	endtask

	task automatic set_reference(input quat_t r);
		write_reg(REG_REF_W, r.w);
		write_reg(REG_REF_X, r.x);
		write_reg(REG_REF_Y, r.y);
		write_reg(REG_REF_Z, r.z);
	endtask

	// wait until every sample has been consumed and answered
	task automatic drain();
		while (sample_queue.size() > 0 || samp.valid || expected_errs.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [SB-1:0] pick_extreme();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h4000;
			4: return 16'hc000;
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic quat_t random_quat();
		quat_t q;
		if ($urandom_range(9) == 0) begin
			q = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
		end else if ($urandom_range(3) == 0) begin
			// small rotation error around the reference
			q.w = ref_q.w + SB'($signed($urandom_range(64)) - 32);
			q.x = ref_q.x + SB'($signed($urandom_range(64)) - 32);
			q.y = ref_q.y + SB'($signed($urandom_range(64)) - 32);
			q.z = ref_q.z + SB'($signed($urandom_range(64)) - 32);
		end else begin
			q = {SB'($urandom), SB'($urandom), SB'($urandom), SB'($urandom)};
		end
		return q;
	endfunction

	initial begin
		quat_t refs[6];
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		refs[0] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		refs[1] = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
		refs[2] = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
		refs[3] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
		refs[4] = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0};
		refs[5] = '{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset reference: zero, identity, opposites, extremes
		sample_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		sample_queue.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		sample_queue.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		sample_queue.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		sample_queue.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0});
		sample_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
		sample_queue.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
		sample_queue.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
		sample_queue.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
		sample_queue.push_back('{-16'sd1, 16'sd1, -16'sd1, 16'sd1});
		sample_queue.push_back('{16'sd16384, 16'sd1, 16'sd0, 16'sd0});
		sample_queue.push_back('{-16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
		drain();

		// random phases across several references, one stretch without idling
		for (int p = 0; p < 8; p++) begin
			if (p < 6) set_reference(refs[p]);
			else set_reference(random_quat());
			quiet = (p == 2);
			for (int n = 0; n < 140; n++) sample_queue.push_back(random_quat());
			drain();
		end
		quiet = 0;

		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
